// ----- hdl/pdc_pkg.sv -----
// shared constants and codes for the pwm period and duty capture block
package pdc_pkg;

    // default sizing
    localparam int PDC_CHANNELS     = 4;
    localparam int PDC_COUNTER_BITS = 16;
    localparam int PDC_SLOTS        = 8;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int CHAN_W  = 2;
    localparam int CAP_W   = 16;
    localparam int KIND_W  = 2;
    localparam int OSLOT_W = 3;
    localparam int TICK_W  = 48;
    localparam int OVF_W   = 32;

    // beat widths on the streams
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = OP_W + CHAN_W + 1;
    localparam int M_DATA_W = 56;
    localparam int M_USER_W = KIND_W + CHAN_W;

    // event codes
    localparam logic [OP_W-1:0] OP_OVERFLOW = 2'd0;
    localparam logic [OP_W-1:0] OP_RISE     = 2'd1;
    localparam logic [OP_W-1:0] OP_FALL     = 2'd2;

    // stored measurement codes
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PERIOD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HIGH   = 2'd2;

endpackage

// ----- hdl/pwm_period_duty_capture_top.sv -----
// pwm period and high-time capture, one event beat per cycle while m_tready stays high
//
// the slave stream carries timer events: s_tuser holds the event kind
// (overflow, rising capture, falling capture), the channel and the
// pending-update flag; s_tdata holds the latched timer count.
// every event beat yields exactly one result beat on the master stream:
// m_tuser holds what was measured (nothing, period, high time) and the
// channel, m_tdata holds the ring slot and the 48-bit tick count.
// an accepted beat is held in the input register, then the tick
// math (32-bit overflow add, then one wide compare and subtract)
// runs into the result register, which drives m_tvalid. one beat
// per cycle is sustained while m_tready stays high.
// when the receiver stalls the result register holds and the input
// register still takes one more beat, after which s_tready drops.
// reset clears the per-channel overflow counts, rise references and
// ring slots, and empties both registers.
module pwm_period_duty_capture_top
    import pdc_pkg::*;
#(
    parameter int CHANNELS     = PDC_CHANNELS,
    parameter int COUNTER_BITS = PDC_COUNTER_BITS,
    parameter int SLOTS        = PDC_SLOTS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // capture_value
    input  logic [S_USER_W-1:0] s_tuser,   // opcode, channel, update_pending
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_slot, ticks, zero pad
    output logic [M_USER_W-1:0] m_tuser    // stored_kind, out_channel
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int EXT_W  = OVF_W + COUNTER_BITS;
    localparam int MW     = (EXT_W + 1 > TICK_W) ? EXT_W + 1 : TICK_W;

    // input register
    logic              in_valid_reg;
    logic [OP_W-1:0]   in_op_reg;
    logic [CHAN_W-1:0] in_chan_reg;
    logic [CAP_W-1:0]  in_cap_reg;
    logic              in_pend_reg;

    // result register
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg,  out_kind_next;
    logic [CHAN_W-1:0]  out_chan_reg;
    logic [OSLOT_W-1:0] out_slot_reg,  out_slot_next;
    logic [TICK_W-1:0]  out_ticks_reg, out_ticks_next;

    // per-channel state
    logic [OVF_W-1:0]  ovf_reg  [CHANNELS];
    logic [CAP_W-1:0]  rise_reg [CHANNELS];
    logic [SLOT_W-1:0] slot_reg [CHANNELS];

    logic              advance;
    logic              proc;
    logic              ch_ok;
    logic [OVF_W-1:0]  sel_ovf,  ovf_next;
    logic [CAP_W-1:0]  sel_rise, rise_next;
    logic [SLOT_W-1:0] sel_slot, slot_next;
    logic [OVF_W-1:0]  adj;
    logic [EXT_W-1:0]  cap_ext;
    logic [EXT_W-1:0]  ext;
    logic [EXT_W-1:0]  ref_ext;
    logic [MW-1:0]     meas;
    logic [SLOT_W+OSLOT_W-1:0] slot_wide;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign proc     = in_valid_reg && advance;

    // pick the addressed channel's state
    always_comb
    begin
        sel_ovf  = '0;
        sel_rise = '0;
        sel_slot = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (int'(in_chan_reg) == i)
            begin
                sel_ovf  = ovf_reg[i];
                sel_rise = rise_reg[i];
                sel_slot = slot_reg[i];
            end
        end
        if (int'(sel_slot) >= SLOTS)
        begin
            sel_slot = '0;
        end
    end

    assign ch_ok = int'(in_chan_reg) < CHANNELS;

    // extended tick value and wrap-aware difference
    always_comb
    begin
        adj     = sel_ovf + OVF_W'(in_pend_reg);
        cap_ext = EXT_W'(in_cap_reg) & ((EXT_W'(1) << COUNTER_BITS) - EXT_W'(1));
        ext     = (EXT_W'(adj) << COUNTER_BITS) | cap_ext;
        ref_ext = EXT_W'(sel_rise);
        if (ext > ref_ext)
        begin
            meas = MW'(ext) - MW'(ref_ext);
        end
        else
        begin
            meas = (MW'(1) << COUNTER_BITS) - MW'(ref_ext) + MW'(ext);
        end
    end

    // result fields and next state of the addressed channel
    always_comb
    begin
        out_kind_next  = KIND_NONE;
        out_ticks_next = '0;
        ovf_next       = sel_ovf;
        rise_next      = sel_rise;
        slot_next      = sel_slot;
        case (in_op_reg)
            OP_OVERFLOW:
            begin
                ovf_next = sel_ovf + OVF_W'(1);
            end
            OP_RISE:
            begin
                if (sel_rise != '0)
                begin
                    out_kind_next  = KIND_PERIOD;
                    out_ticks_next = meas[TICK_W-1:0];
                end
                rise_next = in_cap_reg & CAP_W'(cap_ext);
                ovf_next  = '0;
                slot_next = (sel_slot == SLOT_W'(SLOTS - 1)) ? '0 : sel_slot + SLOT_W'(1);
            end
            OP_FALL:
            begin
                out_kind_next  = KIND_HIGH;
                out_ticks_next = meas[TICK_W-1:0];
            end
            default:
            begin
                out_kind_next = KIND_NONE;
            end
        endcase
        if (!ch_ok)
        begin
            out_kind_next  = KIND_NONE;
            out_ticks_next = '0;
        end
        slot_wide     = {{OSLOT_W{1'b0}}, sel_slot};
        out_slot_next = ch_ok ? slot_wide[OSLOT_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ovf_reg[i]  <= '0;
                rise_reg[i] <= '0;
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (proc && int'(in_chan_reg) == i)
                begin
                    ovf_reg[i]  <= ovf_next;
                    rise_reg[i] <= rise_next;
                    slot_reg[i] <= slot_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cap_reg  <= s_tdata[CAP_W-1:0];
            in_op_reg   <= s_tuser[OP_W-1:0];
            in_chan_reg <= s_tuser[OP_W+CHAN_W-1:OP_W];
            in_pend_reg <= s_tuser[OP_W+CHAN_W];
        end
        if (proc)
        begin
            out_kind_reg  <= out_kind_next;
            out_chan_reg  <= in_chan_reg;
            out_slot_reg  <= out_slot_next;
            out_ticks_reg <= out_ticks_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_chan_reg, out_kind_reg};
    assign m_tdata  = {{(M_DATA_W - TICK_W - OSLOT_W){1'b0}}, out_ticks_reg, out_slot_reg};

    // input stage only stalls while it holds a beat
    a_stall_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stage stalled while empty");

    // nothing stored means zero ticks
    a_none_zero_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_kind_reg == KIND_NONE) |-> out_ticks_reg == '0)
        else $error("ticks nonzero with no measurement");

    // a processed rise clears that channel's overflow count
    a_rise_clears_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && ch_ok && in_op_reg == OP_RISE) |=> sel_ovf == '0 || in_chan_reg != $past(in_chan_reg))
        else $error("overflow count not cleared by rise");

    // an out-of-range channel reports slot zero and stores nothing
    a_bad_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && int'(out_chan_reg) >= CHANNELS) |-> (out_slot_reg == '0 && out_kind_reg == KIND_NONE))
        else $error("result for unknown channel");

endmodule

// ----- sim/tb_pwm_period_duty_capture_top.sv -----
// self-checking testbench for the pwm period and duty capture top
module tb_pwm_period_duty_capture_top;
    import pdc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int              CYCLE_LIMIT = 200000;
    localparam int              PHASE_ITEMS = 450;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAN_W-1:0] ch;
        logic [CAP_W-1:0]  cap;
        logic              pend;
    } pwm_event_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAN_W-1:0]  ch;
        logic [OSLOT_W-1:0] slot;
        logic [TICK_W-1:0]  ticks;
    } capture_result_t;

    typedef struct packed {
        pwm_event_t      ev;
        logic            typed;
        capture_result_t res;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // capture_value
    logic [S_USER_W-1:0] s_tuser = '0;   // opcode, channel, update_pending
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // out_slot, ticks, zero pad
    logic [M_USER_W-1:0] m_tuser;        // stored_kind, out_channel

    // predictor state, one entry per channel
    logic [OVF_W-1:0]   ovf_cnt  [PDC_CHANNELS];
    logic [CAP_W-1:0]   rise_ref [PDC_CHANNELS];
    logic [OSLOT_W-1:0] cur_slot [PDC_CHANNELS];

    capture_result_t expected_meas_q[$];
    stim_row_t       directed_rows[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int err_cnt      = 0;
    int n_events     = 0;
    int n_results    = 0;
    int n_periods    = 0;
    int n_high       = 0;
    int cycle_cnt    = 0;

    pwm_period_duty_capture_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_pwm_period_duty_capture_top: done, errors");
            $finish;
        end
    end

    // ticks between two extended counts, wrap formula when not positive
    function automatic logic [TICK_W-1:0] elapsed_ticks(input logic [TICK_W:0] ext,
                                                         input logic [CAP_W-1:0] ref_cnt);
        logic [TICK_W:0] diff;
        if (ext > {33'd0, ref_cnt})
            diff = ext - {33'd0, ref_cnt};
        else
            diff = (49'd1 << PDC_COUNTER_BITS) - {33'd0, ref_cnt} + ext;
        return diff[TICK_W-1:0];
    endfunction

    function automatic capture_result_t predict_capture(input pwm_event_t ev);
        capture_result_t r;
        logic [OVF_W-1:0] adj;
        logic [TICK_W:0]  ext;
        r.kind  = KIND_NONE;
        r.ch    = ev.ch;
        r.slot  = '0;
        r.ticks = '0;
        if (ev.ch < PDC_CHANNELS)
        begin
            r.slot = cur_slot[ev.ch];
            adj    = ovf_cnt[ev.ch] + OVF_W'(ev.pend);
            ext    = {1'b0, adj, ev.cap};
            if (ev.op == OP_OVERFLOW)
            begin
                ovf_cnt[ev.ch] = ovf_cnt[ev.ch] + OVF_W'(1);
            end
            else if (ev.op == OP_RISE)
            begin
                // a zero reference means no earlier rise to measure from
                if (rise_ref[ev.ch] != '0)
                begin
                    r.kind  = KIND_PERIOD;
                    r.ticks = elapsed_ticks(ext, rise_ref[ev.ch]);
                end
                rise_ref[ev.ch] = ev.cap;
                ovf_cnt[ev.ch]  = '0;
                cur_slot[ev.ch] = (cur_slot[ev.ch] == OSLOT_W'(PDC_SLOTS - 1)) ?
                                  '0 : cur_slot[ev.ch] + OSLOT_W'(1);
            end
            else if (ev.op == OP_FALL)
            begin
                r.kind  = KIND_HIGH;
                r.ticks = elapsed_ticks(ext, rise_ref[ev.ch]);
            end
        end
        return r;
    endfunction

    function automatic stim_row_t event_row(input logic [OP_W-1:0] op,
                                            input logic [CHAN_W-1:0] ch,
                                            input logic [CAP_W-1:0] cap,
                                            input logic pend,
                                            input logic typed,
                                            input logic [KIND_W-1:0] kind,
                                            input logic [OSLOT_W-1:0] slot,
                                            input logic [TICK_W-1:0] ticks);
        stim_row_t row;
        row.ev.op     = op;
        row.ev.ch     = ch;
        row.ev.cap    = cap;
        row.ev.pend   = pend;
        row.typed     = typed;
        row.res.kind  = kind;
        row.res.ch    = ch;
        row.res.slot  = slot;
        row.res.ticks = ticks;
        return row;
    endfunction

    function automatic pwm_event_t random_event();
        pwm_event_t ev;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            ev.op = OP_OVERFLOW;
        else if (pick < 68)
            ev.op = OP_RISE;
        else if (pick < 96)
            ev.op = OP_FALL;
        else
            ev.op = OP_UNUSED;
        ev.ch   = CHAN_W'($urandom_range(PDC_CHANNELS - 1));
        ev.pend = ($urandom_range(7) == 0);
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(5))
                0:       ev.cap = 16'h0000;
                1:       ev.cap = 16'h0001;
                2:       ev.cap = 16'h7fff;
                3:       ev.cap = 16'h8000;
                4:       ev.cap = 16'hfffe;
                default: ev.cap = 16'hffff;
            endcase
        end
        else
        begin
            ev.cap = CAP_W'($urandom_range(16'hffff));
        end
        return ev;
    endfunction

    // present one beat after an optional gap, then wait for the handshake
    task automatic drive_event(input pwm_event_t ev, input logic typed,
                               input capture_result_t typed_res);
        capture_result_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ev.cap;
        s_tuser  <= {ev.pend, ev.ch, ev.op};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_capture(ev);
        expected_meas_q.push_back(typed ? typed_res : predicted);
        n_events++;
    endtask

    task automatic wait_drained();
        while (expected_meas_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items);
        pwm_event_t ev;
        int sent;
        int burst;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(19) == 0)
            begin
                // long overflow run on one channel pushes the tick counts up
                burst   = $urandom_range(40, 4);
                ev      = random_event();
                ev.op   = OP_OVERFLOW;
                repeat (burst)
                begin
                    ev.cap  = CAP_W'($urandom_range(16'hffff));
                    ev.pend = ($urandom_range(1) == 1);
                    drive_event(ev, 1'b0, '0);
                end
                sent += burst;
            end
            else
            begin
                drive_event(random_event(), 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        capture_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (m_tuser[KIND_W-1:0] == KIND_PERIOD)
                    n_periods++;
                if (m_tuser[KIND_W-1:0] == KIND_HIGH)
                    n_high++;
                if (expected_meas_q.size() == 0)
                begin
                    $error("result beat with no expectation waiting: tuser %h tdata %h",
                           m_tuser, m_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = expected_meas_q.pop_front();
                    if (m_tuser[KIND_W-1:0] !== want.kind)
                    begin
                        $error("stored_kind: expected %0d, got %0d", want.kind,
                               m_tuser[KIND_W-1:0]);
                        err_cnt++;
                    end
                    if (m_tuser[KIND_W +: CHAN_W] !== want.ch)
                    begin
                        $error("out_channel: expected %0d, got %0d", want.ch,
                               m_tuser[KIND_W +: CHAN_W]);
                        err_cnt++;
                    end
                    if (m_tdata[OSLOT_W-1:0] !== want.slot)
                    begin
                        $error("out_slot: expected %0d, got %0d", want.slot,
                               m_tdata[OSLOT_W-1:0]);
                        err_cnt++;
                    end
                    if (m_tdata[OSLOT_W +: TICK_W] !== want.ticks)
                    begin
                        $error("ticks: expected %h, got %h", want.ticks,
                               m_tdata[OSLOT_W +: TICK_W]);
                        err_cnt++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin
        for (int c = 0; c < PDC_CHANNELS; c++)
        begin
            ovf_cnt[c]  = '0;
            rise_ref[c] = '0;
            cur_slot[c] = '0;
        end

        // unused opcode, falls with no rise, rises from a zero reference, overflows
        directed_rows.push_back(event_row(OP_UNUSED,   2'd0, 16'hffff, 1'b1,
                                          1'b1, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_FALL,     2'd1, 16'h0000, 1'b0,
                                          1'b1, KIND_HIGH, 3'd0, 48'h10000));
        directed_rows.push_back(event_row(OP_FALL,     2'd1, 16'hffff, 1'b1,
                                          1'b1, KIND_HIGH, 3'd0, 48'h1ffff));
        directed_rows.push_back(event_row(OP_RISE,     2'd2, 16'h0000, 1'b0,
                                          1'b1, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd2, 16'hffff, 1'b0,
                                          1'b1, KIND_NONE, 3'd1, 48'd0));
        directed_rows.push_back(event_row(OP_OVERFLOW, 2'd2, 16'h0000, 1'b0,
                                          1'b1, KIND_NONE, 3'd2, 48'd0));
        directed_rows.push_back(event_row(OP_OVERFLOW, 2'd2, 16'h5a5a, 1'b1,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_OVERFLOW, 2'd2, 16'ha5a5, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        // period across overflows plus a pending update
        directed_rows.push_back(event_row(OP_RISE,     2'd2, 16'hffff, 1'b1,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        // capture below the reference, then equal to it
        directed_rows.push_back(event_row(OP_RISE,     2'd2, 16'h8000, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_FALL,     2'd2, 16'h8000, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_OVERFLOW, 2'd0, 16'h0000, 1'b0,
                                          1'b1, KIND_NONE, 3'd0, 48'd0));
        // nine rises on one channel walk the ring past its last slot
        directed_rows.push_back(event_row(OP_RISE,     2'd3, 16'h0001, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd3, 16'h00ff, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd3, 16'h0f00, 1'b1,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd3, 16'h7fff, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd3, 16'h8000, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd3, 16'hfffe, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd3, 16'hffff, 1'b1,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd3, 16'h0000, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd3, 16'h5555, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_UNUSED,   2'd3, 16'h1234, 1'b0,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_FALL,     2'd3, 16'hffff, 1'b1,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));
        directed_rows.push_back(event_row(OP_RISE,     2'd1, 16'hffff, 1'b1,
                                          1'b0, KIND_NONE, 3'd0, 48'd0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].res);
        s_tvalid <= 1'b0;
        wait_drained();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(51, 0, PHASE_ITEMS);
        run_phase(0, 51, PHASE_ITEMS);
        run_phase(35, 35, PHASE_ITEMS);

        // give stray result beats time to show up
        repeat (8) @(posedge clk);

        $display("event beats sent: %0d (directed table plus four sender/receiver pressure mixes)",
                 n_events);
        $display("result beats checked: %0d, periods %0d, high times %0d",
                 n_results, n_periods, n_high);
        if (err_cnt == 0)
            $display("tb_pwm_period_duty_capture_top: done, clean");
        else
            $display("tb_pwm_period_duty_capture_top: done, errors");
        $finish;
    end

endmodule
